// ----- rtl/pct_pkg.sv -----
// ----------------------------------------------------------------------------
// pct_pkg
// Shared constants, codes and types of the peer connection table.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

    localparam int ENTRIES = 16;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_UPDATE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // One table entry as it is held in a cell and handed to a neighbor.
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [15:0] connection;
        logic        peer_class;
        logic [63:0] timestamp;
    } t_entry;

    // Per-cell control for the update cycle.
    typedef struct packed {
        logic shift_in;   // take the entry of the newer neighbor
        logic shift_out;  // take the entry of the older neighbor
        logic ts_wr;      // overwrite the timestamp
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/pct_cell.sv -----
// ----------------------------------------------------------------------------
// pct_cell
// One slot of the table: holds an entry, compares it against the key and
// moves entries to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_by_conn,
    input  wire  [31:0]          i_key_address,
    input  wire  [15:0]          i_key_connection,
    input  wire  [63:0]          i_time_now,
    input  pct_pkg::t_cell_ctl   i_ctl,
    input  pct_pkg::t_entry      i_newer,
    input  pct_pkg::t_entry      i_older,
    output pct_pkg::t_entry      o_entry,
    output logic                 o_match
);
    import pct_pkg::*;

    t_entry r_entry;
    logic   r_match;
    logic   n_match;

    assign n_match = r_entry.valid &&
                     (i_by_conn ? (r_entry.connection == i_key_connection)
                                : (r_entry.address == i_key_address));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_match       <= 1'b0;
        end else begin
            r_match <= n_match;
            if (i_ctl.shift_in) begin
                r_entry.valid <= i_newer.valid;
            end else if (i_ctl.shift_out) begin
                r_entry.valid <= i_older.valid;
            end
        end
    end

    // Payload carries no reset; only valid slots are ever compared.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift_in) begin
            r_entry.address    <= i_newer.address;
            r_entry.connection <= i_newer.connection;
            r_entry.peer_class <= i_newer.peer_class;
            r_entry.timestamp  <= i_newer.timestamp;
        end else if (i_ctl.shift_out) begin
            r_entry.address    <= i_older.address;
            r_entry.connection <= i_older.connection;
            r_entry.peer_class <= i_older.peer_class;
            r_entry.timestamp  <= i_older.timestamp;
        end else if (i_ctl.ts_wr) begin
            r_entry.timestamp  <= i_time_now;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ----- rtl/peer_connection_table_top.sv -----
// ----------------------------------------------------------------------------
// peer_connection_table_top
// Associative peer table kept newest first in a row of cells.
// ----------------------------------------------------------------------------
// Timing: a command accepted in idle passes through the match cycle and the
//   update cycle; its result strobe o_done is raised in the result cycle.
// Handshake: busy is high during the match and update cycles, and a new
//   command may start during the result cycle.
// Reset: synchronous active-low i_rst_n clears all valid bits, the entry count
//   and the controller; the result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_connection_table_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  wire  [1:0]   i_kind,
    input  wire  [31:0]  i_ip_address,
    input  wire  [15:0]  i_connection,
    input  wire          i_new_type,
    input  wire  [63:0]  i_time_now,
    output logic         o_done,
    output logic [1:0]   o_status,
    output logic         o_found_type,
    output logic [pct_pkg::CNT_W-1:0] o_entry_count
);
    import pct_pkg::*;

    // Controller: idle, then a match state in which every cell compares its entry
    // with the key, then an apply state in which the table is rewritten.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [1:0]       r_kind;
    logic [31:0]      r_address;
    logic [15:0]      r_connection;
    logic             r_new_type;
    logic [63:0]      r_time;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic             r_found_type;

    t_entry           w_entry [ENTRIES];
    t_cell_ctl        w_ctl   [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_first;    // one-hot of the newest matching slot
    logic [ENTRIES-1:0] w_from;     // slots at or after the newest match
    logic [ENTRIES-1:0] w_type_hit;
    logic             w_found;
    logic             w_apply;
    logic             w_full;
    logic             w_add_ok;
    logic             w_del_ok;
    t_entry           w_head;
    t_entry           w_tail;

    assign busy    = (r_state != S_IDLE);
    assign w_apply = (r_state == S_APPLY);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_MATCH;
            S_MATCH: n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // The command beat is captured at acceptance and held for the whole item.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_kind       <= i_kind;
            r_address    <= i_ip_address;
            r_connection <= i_connection;
            r_new_type   <= i_new_type;
            r_time       <= i_time_now;
        end
    end

    // The lowest set bit of the match vector is the newest match. Everything
    // from that slot to the tail moves one slot toward the head on a delete.
    assign w_first = w_match & (~w_match + {{(ENTRIES-1){1'b0}}, 1'b1});
    assign w_from  = ~(w_first - {{(ENTRIES-1){1'b0}}, 1'b1});
    assign w_found = |w_match;

    assign w_full   = (r_count >= CNT_W'(ENTRIES));
    assign w_add_ok = w_apply && (r_kind == KIND_ADD) && !w_full;
    assign w_del_ok = w_apply && (r_kind == KIND_DELETE) && w_found;

    // New entry enters at the head; an empty entry enters at the tail.
    assign w_head = '{valid: 1'b1, address: r_address, connection: r_connection,
                      peer_class: r_new_type, timestamp: r_time};
    assign w_tail = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            assign w_ctl[g].shift_in  = w_add_ok;
            assign w_ctl[g].shift_out = w_del_ok && w_from[g];
            assign w_ctl[g].ts_wr     = w_apply && (r_kind == KIND_UPDATE) && w_first[g];
            assign w_type_hit[g]      = w_first[g] && w_entry[g].peer_class;

            pct_cell u_cell (
                .i_clk            (i_clk),
                .i_rst_n          (i_rst_n),
                .i_by_conn        (r_kind == KIND_UPDATE),
                .i_key_address    (r_address),
                .i_key_connection (r_connection),
                .i_time_now       (r_time),
                .i_ctl            (w_ctl[g]),
                .i_newer          ((g == 0) ? w_head : w_entry[(g == 0) ? 0 : g-1]),
                .i_older          ((g == ENTRIES-1) ? w_tail
                                                    : w_entry[(g == ENTRIES-1) ? g : g+1]),
                .o_entry          (w_entry[g]),
                .o_match          (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        unique case (r_kind)
            KIND_ADD: begin
                if (w_full) n_status = ST_FULL;
                else        n_count  = r_count + CNT_W'(1);
            end
            KIND_DELETE: begin
                if (!w_found) n_status = ST_MISS;
                else          n_count  = r_count - CNT_W'(1);
            end
            KIND_LOOKUP, KIND_UPDATE: begin
                if (!w_found) n_status = ST_MISS;
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_apply;
            if (w_apply) begin
                r_count <= n_count;
            end
        end
    end

    // Result beat is registered and shown for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_status     <= n_status;
            r_found_type <= (r_kind == KIND_LOOKUP) && (|w_type_hit);
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_type  = r_found_type;
    assign o_entry_count = r_count;

endmodule

`default_nettype wire

// ----- rtl/pct_checker.sv -----
// ----------------------------------------------------------------------------
// pct_checker
// Port-level checks of the peer connection table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    input  wire                        busy,
    input  wire                        o_done,
    input  wire  [1:0]                 o_status,
    input  wire                        o_found_type,
    input  wire  [pct_pkg::CNT_W-1:0]  o_entry_count
);
    import pct_pkg::*;

    // Every accepted command produces its result beat.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result beat missing three cycles after a command");

    // The result beat never overlaps the cycles in which the table works.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // A refused add only happens on a full table.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_entry_count == CNT_W'(ENTRIES)))
        else $error("full status with room left");

    // A type of one only comes with a hit.
    a_type_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found_type) |-> (o_status == ST_OK))
        else $error("found type on a miss");

    // The count never exceeds the table size at a result beat.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_entry_count <= CNT_W'(ENTRIES)))
        else $error("entry count beyond table size");

endmodule

bind peer_connection_table_top pct_checker u_pct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_found_type  (o_found_type),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the peer connection table. Commands are driven with
// a start/busy handshake and random gaps. A scoreboard keeps its own newest
// first copy of the table, works out each command's expected status, type and
// entry count, and checks them against the strobed results in order.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pct_pkg::*;

    // Expected outcome of one command beat.
    typedef struct packed {
        logic [1:0]       status;
        logic             found_type;
        logic [CNT_W-1:0] entry_count;
    } t_peer_result;

    // The scoreboard holds a compacted copy of the table: slot 0 is the newest
    // entry and slots 0..used-1 are the live ones. Each accepted command is
    // applied to it at once, and the outcome is queued until the block
    // strobes the matching result.
    class peer_table_scoreboard;
        logic [31:0]  address [ENTRIES];
        logic [15:0]  connection [ENTRIES];
        logic         peer_class [ENTRIES];
        logic [63:0]  stamp [ENTRIES];
        int           used;
        int           errors;
        t_peer_result expected_results[$];

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function void move_entry(int dst, int src);
            address[dst]    = address[src];
            connection[dst] = connection[src];
            peer_class[dst] = peer_class[src];
            stamp[dst]      = stamp[src];
        endfunction

        function int newest_by_address(logic [31:0] key);
            for (int i = 0; i < used; i++)
                if (address[i] == key) return i;
            return -1;
        endfunction

        function int newest_by_connection(logic [15:0] key);
            for (int i = 0; i < used; i++)
                if (connection[i] == key) return i;
            return -1;
        endfunction

        function void record_command(logic [1:0] kind, logic [31:0] addr,
                                     logic [15:0] conn, logic ntype,
                                     logic [63:0] now);
            t_peer_result res;
            int           k;
            res.status     = ST_OK;
            res.found_type = 1'b0;
            case (kind)
                KIND_ADD: begin
                    if (used >= ENTRIES) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int i = used; i > 0; i--) move_entry(i, i - 1);
                        address[0]    = addr;
                        connection[0] = conn;
                        peer_class[0] = ntype;
                        stamp[0]      = now;
                        used++;
                    end
                end
                KIND_DELETE: begin
                    k = newest_by_address(addr);
                    if (k < 0) begin
                        res.status = ST_MISS;
                    end else begin
                        for (int i = k; i + 1 < used; i++) move_entry(i, i + 1);
                        used--;
                    end
                end
                KIND_LOOKUP: begin
                    k = newest_by_address(addr);
                    if (k < 0) res.status = ST_MISS;
                    else res.found_type = peer_class[k];
                end
                default: begin
                    k = newest_by_connection(conn);
                    if (k < 0) res.status = ST_MISS;
                    else stamp[k] = now;
                end
            endcase
            res.entry_count = CNT_W'(used);
            expected_results.push_back(res);
        endfunction

        task report(string what);
            errors++;
            $display("%0t: mismatch: %s", $realtime, what);
        endtask

        task check_result(logic [1:0] status, logic found_type,
                          logic [CNT_W-1:0] count);
            t_peer_result exp;
            if (expected_results.size() == 0) begin
                report($sformatf("result with none expected: status %0d type %0d count %0d",
                                 status, found_type, count));
                return;
            end
            exp = expected_results.pop_front();
            if (status !== exp.status)
                report($sformatf("status %0d, expected %0d", status, exp.status));
            if (found_type !== exp.found_type)
                report($sformatf("found type %0d, expected %0d", found_type, exp.found_type));
            if (count !== exp.entry_count)
                report($sformatf("entry count %0d, expected %0d", count, exp.entry_count));
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_kind;
    logic [31:0]      i_ip_address;
    logic [15:0]      i_connection;
    logic             i_new_type;
    logic [63:0]      i_time_now;
    logic             o_done;
    logic [1:0]       o_status;
    logic             o_found_type;
    logic [CNT_W-1:0] o_entry_count;

    peer_table_scoreboard sb = new();

    // Small pools of keys so that deletes, lookups and updates hit often.
    logic [31:0] addr_pool [8];
    logic [15:0] conn_pool [8];

    peer_connection_table_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_ip_address  (i_ip_address),
        .i_connection  (i_connection),
        .i_new_type    (i_new_type),
        .i_time_now    (i_time_now),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_type  (o_found_type),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A hard limit on the run; a correct run ends far sooner.
    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    // Results are sampled at the rising edge that ends the strobe cycle. The
    // receiver cannot stall, so every strobe is one beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_status, o_found_type, o_entry_count);
        end
    end

    // Present one command at the falling edge and hold it until the rising
    // edge at which busy is low. Start is left high so that a following
    // command can go out back to back without a dead cycle.
    task issue_command(input logic [1:0] kind, input logic [31:0] addr,
                       input logic [15:0] conn, input logic ntype,
                       input logic [63:0] now);
        @(negedge i_clk);
        start        = 1'b1;
        i_kind       = kind;
        i_ip_address = addr;
        i_connection = conn;
        i_new_type   = ntype;
        i_time_now   = now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.record_command(kind, addr, conn, ntype, now);
    endtask

    // A sender gap. The command fields carry noise while start is low, which
    // the block must ignore.
    task pause_sender(input int cycles);
        @(negedge i_clk);
        start        = 1'b0;
        i_kind       = 2'($urandom);
        i_ip_address = $urandom;
        i_connection = 16'($urandom);
        i_new_type   = 1'($urandom);
        i_time_now   = {$urandom, $urandom};
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // One random command. Keys mostly come from the pools; the rest are fully
    // random so that every key bit toggles and misses stay common enough.
    task random_command(input int add_pct);
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [15:0] conn;
        if ($urandom_range(0, 99) < add_pct) begin
            kind = KIND_ADD;
        end else begin
            case ($urandom_range(0, 2))
                0:       kind = KIND_DELETE;
                1:       kind = KIND_LOOKUP;
                default: kind = KIND_UPDATE;
            endcase
        end
        addr = ($urandom_range(0, 7) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
        conn = ($urandom_range(0, 7) == 0) ? 16'($urandom) : conn_pool[$urandom_range(0, 7)];
        issue_command(kind, addr, conn, 1'($urandom_range(0, 1)), {$urandom, $urandom});
    endtask

    initial begin
        int add_pct;
        bit idle_on;

        // Every input is known from time zero; reset is held low at first.
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = KIND_ADD;
        i_ip_address = '0;
        i_connection = '0;
        i_new_type   = 1'b0;
        i_time_now   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. First, every keyed command against an empty table
        // must miss without changing the count.
        issue_command(KIND_LOOKUP, 32'h0000_0000, 16'h0000, 1'b1, '0);
        issue_command(KIND_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '1);
        issue_command(KIND_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '1);

        // Extreme field values, then a duplicate address that must shadow the
        // older entry for lookups and deletes.
        issue_command(KIND_ADD, 32'h0000_0000, 16'h0000, 1'b0, '0);
        issue_command(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '1);
        issue_command(KIND_ADD, 32'h0000_0000, 16'h1234, 1'b1, 64'h8000_0000_0000_0001);
        issue_command(KIND_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0, '0);
        issue_command(KIND_UPDATE, 32'h0000_0000, 16'h0000, 1'b0, 64'h0123_4567_89AB_CDEF);
        issue_command(KIND_DELETE, 32'h0000_0000, 16'h0000, 1'b0, '0);
        issue_command(KIND_LOOKUP, 32'h0000_0000, 16'hFFFF, 1'b1, '1);

        // Fill the table to the last slot, then try one more add, which must
        // be refused as full. A delete of the next to oldest entry of a full table
        // follows.
        for (int i = 0; i < ENTRIES - 2; i++)
            issue_command(KIND_ADD, $urandom, 16'(i), 1'(i), {$urandom, $urandom});
        issue_command(KIND_ADD, 32'h5A5A_5A5A, 16'hA5A5, 1'b1, '1);
        issue_command(KIND_DELETE, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0);

        // Random part in phases. Each phase draws fresh key pools and an add
        // rate, so the table is driven both toward empty and toward full.
        // The last two phases run without sender gaps.
        for (int phase = 0; phase < 8; phase++) begin
            foreach (addr_pool[j]) addr_pool[j] = $urandom;
            foreach (conn_pool[j]) conn_pool[j] = 16'($urandom);
            case ($urandom_range(0, 2))
                0:       add_pct = 20;
                1:       add_pct = 50;
                default: add_pct = 80;
            endcase
            idle_on = (phase < 6) && ($urandom_range(0, 2) != 0);
            repeat (165) begin
                if (idle_on && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 8));
                random_command(add_pct);
            end
        end

        @(negedge i_clk);
        start = 1'b0;

        // Drain the outstanding results, then keep the block running so that a
        // stray strobe would still be caught.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
